@@ rtl/srr_pkg.sv @@
// Package for the selective-repeat resequencer: register codes, status codes,
// sequencer state type and fixed widths of the configuration port.
// No dependencies.
`default_nettype none

package srr_pkg;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WIN_REG_W   = 5;
    localparam int FIRST_SEQ_W = 16;
    localparam int TUSER_W     = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_SEQ   = 2'd1;

    localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_DUPLICATE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/selective_repeat_resequencer.sv @@
// Selective-repeat ARQ receiver with in-order release: window check, slot
// store, contiguous-run scan and beat-by-beat release. Depends on srr_pkg.
`default_nettype none

// Channel    | Dir | Handshake            | Payload
// -----------+-----+----------------------+---------------------------------------
// s_*        | in  | s_tvalid / s_tready  | s_tdata: pkt_seq, pkt_payload
// m_*        | out | m_tvalid / m_tready  | m_tdata, m_tuser, m_tlast (see ports)
// cfg_*      | in  | cfg_we (no wait)     | cfg_addr, cfg_wdata
//
// Steps: a packet is accepted in idle and then checked; when it is stored, a scan
// over the slot-full bits counts R = packets released (0..W), then one
// beat per released packet (one beat when nothing is released). The scan and
// the release both walk the slot store through a single index/increment unit.
// Reset clears the sequencer, slot-full bits and session counters at once.
// s_tready is high only in idle; a stalled m_tready holds the release walk.
module selective_repeat_resequencer #(
    parameter int MAX_WINDOW   = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int SEQ_BITS     = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // [SEQ_BITS-1:0] pkt_seq, then pkt_payload, zero pad to bytes
    input  wire logic [((SEQ_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // out_seq, out_payload, ack_valid, ack_seq, held_count, zero pad to bytes
    output logic [((2 * SEQ_BITS + PAYLOAD_BITS + 1 + $clog2(MAX_WINDOW + 1) + 7) / 8) * 8 - 1:0]
                      m_tdata,
    // [0] out_valid, [2:1] accept_status
    output logic [srr_pkg::TUSER_W-1:0] m_tuser,
    output logic      m_tlast,

    input  wire logic                          cfg_we,
    input  wire logic [srr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import srr_pkg::*;

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W   = ((SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W) + 1;
    localparam int OUT_RAW = 2 * SEQ_BITS + PAYLOAD_BITS + 1 + CNT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [WIN_REG_W-1:0]   window_reg;
    logic [FIRST_SEQ_W-1:0] first_seq_reg;

    logic [MAX_WINDOW-1:0] full_reg, full_next;
    logic [SEQ_BITS-1:0]     slot_seq_mem [MAX_WINDOW];
    logic [PAYLOAD_BITS-1:0] slot_pay_mem [MAX_WINDOW];
    logic                    mem_we;
    logic                    mem_rd;
    logic [IDX_W-1:0]        mem_idx;

    logic [IDX_W-1:0]    start_reg, start_next;
    logic [SEQ_BITS-1:0] earliest_reg, earliest_next;
    logic                acks_reg, acks_next;
    logic [CNT_W-1:0]    held_reg, held_next;

    // current packet
    logic [SEQ_BITS-1:0]     in_seq_reg, in_seq_next;
    logic [PAYLOAD_BITS-1:0] in_pay_reg, in_pay_next;
    status_t                 status_reg, status_next;

    // shared walk unit: scan then release
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;     // scan count, then beat index
    logic [CNT_W-1:0] total_reg, total_next;

    // output register
    logic                    o_valid_reg, o_valid_next;
    logic                    o_rel_reg, o_rel_next;
    logic [SEQ_BITS-1:0]     o_seq_reg, o_seq_next;
    logic [PAYLOAD_BITS-1:0] o_pay_reg, o_pay_next;
    status_t                 o_status_reg, o_status_next;
    logic                    o_ackv_reg, o_ackv_next;
    logic [SEQ_BITS-1:0]     o_ackseq_reg, o_ackseq_next;
    logic [CNT_W-1:0]        o_held_reg, o_held_next;
    logic                    o_last_reg, o_last_next;

    // ---------------- shared combinational unit ----------------
    logic [CNT_W-1:0]    win;
    logic [IDX_W-1:0]    start_eff;
    logic [CMP_W-1:0]    seq_ext, lo_ext, hi_ext;
    logic                in_window;
    logic [SEQ_BITS-1:0] seq_diff;
    logic [CNT_W:0]      idx_sum;
    logic [IDX_W-1:0]    slot_idx;
    logic                slot_hit;
    logic                scan_more;
    logic [IDX_W-1:0]    pos_inc;
    logic [CNT_W:0]      pos_p1;
    logic                out_free;
    logic                beat_last;
    logic                s_fire;
    logic                cfg_hit;
    logic [SEQ_BITS-1:0] flush_seq;

    always_comb
    begin
        // window in use, clamped to [1, MAX_WINDOW]
        if (window_reg == '0)
        begin
            win = CNT_W'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            win = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win = CNT_W'(window_reg);
        end
    end

    assign start_eff = ((CNT_W + 1)'(start_reg) >= (CNT_W + 1)'(win)) ? '0 : start_reg;

    // linear window test, upper bound not wrapped
    assign seq_ext   = CMP_W'(in_seq_reg);
    assign lo_ext    = CMP_W'(earliest_reg);
    assign hi_ext    = lo_ext + CMP_W'(win);
    assign in_window = (seq_ext >= lo_ext) && (seq_ext < hi_ext);

    // slot = (start + offset) mod W, with start < W and offset < W
    assign seq_diff = in_seq_reg - earliest_reg;
    assign idx_sum  = (CNT_W + 1)'(start_eff) + (CNT_W + 1)'(CNT_W'(seq_diff));
    assign slot_idx = (idx_sum >= (CNT_W + 1)'(win)) ? IDX_W'(idx_sum - (CNT_W + 1)'(win))
                                                     : IDX_W'(idx_sum);
    assign slot_hit = full_reg[slot_idx];

    // walk pointer increment, mod W
    assign pos_p1  = (CNT_W + 1)'(pos_reg) + (CNT_W + 1)'(1);
    assign pos_inc = (pos_p1 == (CNT_W + 1)'(win)) ? '0 : IDX_W'(pos_p1);

    assign scan_more = (cnt_reg < win) && full_reg[pos_reg];
    assign out_free  = !o_valid_reg || m_tready;
    assign beat_last = (total_reg == '0) || (cnt_reg == total_reg - CNT_W'(1));
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_hit   = cfg_we && ((cfg_addr == REG_WINDOW_SIZE) || (cfg_addr == REG_FIRST_SEQ));
    assign flush_seq = (cfg_addr == REG_FIRST_SEQ) ? SEQ_BITS'(cfg_wdata)
                                                   : SEQ_BITS'(first_seq_reg);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (in_window && !slot_hit)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free && beat_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        full_next     = full_reg;
        start_next    = start_reg;
        earliest_next = earliest_reg;
        acks_next     = acks_reg;
        held_next     = held_reg;
        in_seq_next   = in_seq_reg;
        in_pay_next   = in_pay_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        mem_we        = 1'b0;
        mem_rd        = 1'b0;
        mem_idx       = slot_idx;

        o_valid_next  = o_valid_reg && !m_tready;
        o_rel_next    = o_rel_reg;
        o_seq_next    = o_seq_reg;
        o_pay_next    = o_pay_reg;
        o_status_next = o_status_reg;
        o_ackv_next   = o_ackv_reg;
        o_ackseq_next = o_ackseq_reg;
        o_held_next   = o_held_reg;
        o_last_next   = o_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    in_seq_next = s_tdata[SEQ_BITS-1:0];
                    in_pay_next = s_tdata[SEQ_BITS +: PAYLOAD_BITS];
                end
            end
            S_CHECK:
            begin
                start_next = start_eff;
                total_next = '0;
                cnt_next   = '0;
                if (!in_window)
                begin
                    status_next = ST_OUTSIDE;
                end
                else
                begin
                    acks_next = 1'b1;
                    if (slot_hit)
                    begin
                        status_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        status_next        = ST_STORED;
                        mem_we             = 1'b1;
                        full_next[slot_idx] = 1'b1;
                        held_next          = held_reg + CNT_W'(1);
                        pos_next           = start_eff;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_more)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    pos_next = pos_inc;
                end
                else
                begin
                    // run length known: commit session state, rewind for release
                    total_next    = cnt_reg;
                    cnt_next      = '0;
                    pos_next      = start_reg;
                    start_next    = pos_reg;
                    earliest_next = earliest_reg + SEQ_BITS'(cnt_reg);
                    held_next     = held_reg - cnt_reg;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    o_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_ackv_next   = acks_reg;
                    o_ackseq_next = acks_reg ? (earliest_reg - SEQ_BITS'(1)) : '0;
                    o_held_next   = held_reg;
                    o_last_next   = beat_last;
                    if (total_reg == '0)
                    begin
                        o_rel_next = 1'b0;
                        o_seq_next = '0;
                        o_pay_next = '0;
                    end
                    else
                    begin
                        // slot contents load straight into the output register
                        o_rel_next         = 1'b1;
                        mem_rd             = 1'b1;
                        full_next[pos_reg] = 1'b0;
                        cnt_next           = cnt_reg + CNT_W'(1);
                        pos_next           = pos_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // register write flushes the session
        if (cfg_hit)
        begin
            full_next     = '0;
            start_next    = '0;
            held_next     = '0;
            acks_next     = 1'b0;
            earliest_next = flush_seq;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            first_seq_reg <= '0;
            full_reg      <= '0;
            start_reg     <= '0;
            earliest_reg  <= '0;
            acks_reg      <= 1'b0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            pos_reg       <= '0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            full_reg     <= full_next;
            start_reg    <= start_next;
            earliest_reg <= earliest_next;
            acks_reg     <= acks_next;
            held_reg     <= held_next;
            cnt_reg      <= cnt_next;
            total_reg    <= total_next;
            pos_reg      <= pos_next;
            o_valid_reg  <= o_valid_next;
            if (cfg_we && (cfg_addr == REG_WINDOW_SIZE))
            begin
                window_reg <= WIN_REG_W'(cfg_wdata);
            end
            if (cfg_we && (cfg_addr == REG_FIRST_SEQ))
            begin
                first_seq_reg <= FIRST_SEQ_W'(cfg_wdata);
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_seq_reg   <= in_seq_next;
        in_pay_reg   <= in_pay_next;
        status_reg   <= status_next;
        o_rel_reg    <= o_rel_next;
        if (mem_rd)
        begin
            o_seq_reg <= slot_seq_mem[pos_reg];
            o_pay_reg <= slot_pay_mem[pos_reg];
        end
        else
        begin
            o_seq_reg <= o_seq_next;
            o_pay_reg <= o_pay_next;
        end
        o_status_reg <= o_status_next;
        o_ackv_reg   <= o_ackv_next;
        o_ackseq_reg <= o_ackseq_next;
        o_held_reg   <= o_held_next;
        o_last_reg   <= o_last_next;
    end

    // slot store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_seq_mem[mem_idx] <= in_seq_reg;
            slot_pay_mem[mem_idx] <= in_pay_reg;
        end
    end

    // ---------------- ports ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = o_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_status_reg, o_rel_reg};
    assign m_tdata  = OUT_W'({o_held_reg, o_ackseq_reg, o_ackv_reg, o_pay_reg, o_seq_reg});

endmodule

`default_nettype wire
